@@ src/gtg_pkg.sv @@
`timescale 1ns / 1ps

package gtg_pkg;

  // register map of the configuration port
  typedef enum logic [2:0] {
    REG_GOAL_X       = 3'd0,
    REG_GOAL_Y       = 3'd1,
    REG_GAIN_P       = 3'd2,
    REG_GAIN_I       = 3'd3,
    REG_GAIN_D       = 3'd4,
    REG_CRUISE_SPEED = 3'd5
  } gtg_reg_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // one odometry sample
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] yaw;
  } gtg_in_t;

  // one velocity command
  typedef struct packed {
    logic signed [13:0] turn_rate;
    logic        [14:0] speed_out;
  } gtg_out_t;

  // pid gains, Q8.8
  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
  } gtg_gain_t;

  // atan(2^-i) in Q.30 radians
  localparam int TableLen = 24;
  localparam logic [31:0] ATAN_Q30 [TableLen] = '{
    32'h3243F6A9, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // angle fraction bits of the ports
  localparam int IoAngleFrac = 13;
  // +/-0.8 in Q1.13
  localparam int TurnLimit = 6554;

endpackage

@@ src/gtg_cordic.sv @@
`timescale 1ns / 1ps

module gtg_cordic #(
  parameter int STEPS = 16,
  parameter int AF    = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [24:0]   dx_i,
  input  logic signed [24:0]   dy_i,
  output logic                 done_o,
  output logic signed [AF+3:0] theta_o
);
  import gtg_pkg::*;

  localparam int XW   = 52;
  localparam int ZW   = AF + 4;
  localparam int CW   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int ASH  = 30 - AF;
  localparam logic [63:0] ARND  = 64'd1 << (29 - AF);
  localparam logic [63:0] HPI64 = (HALF_PI_Q30 + ARND) >> ASH;
  localparam logic signed [ZW-1:0] HPI = ZW'(HPI64);
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d, zero_q, zero_d;

  logic signed [XW-1:0] x0, y0, xsh, ysh;
  logic [63:0] atan64;
  logic signed [ZW-1:0] a;

  // vector scaled by 2^24
  assign x0 = {{(XW-49){dx_i[24]}}, dx_i, 24'b0};
  assign y0 = {{(XW-49){dy_i[24]}}, dy_i, 24'b0};

  // rounded table angle of this step
  assign atan64 = {32'b0, ATAN_Q30[5'(cnt_q)]};
  assign a      = ZW'((atan64 + ARND) >> ASH);
  assign xsh    = x_q >>> cnt_q;
  assign ysh    = y_q >>> cnt_q;

  // pre-rotation on start, then one micro-rotation per cycle
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    zero_d = zero_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      zero_d = (dx_i == '0) && (dy_i == '0);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x_d = y0;
          y_d = -x0;
          z_d = HPI;
        end else begin
          x_d = -y0;
          y_d = x0;
          z_d = -HPI;
        end
      end else begin
        x_d = x0;
        y_d = y0;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + ysh;
        y_d = y_q - xsh;
        z_d = z_q + a;
      end else begin
        x_d = x_q - ysh;
        y_d = y_q + xsh;
        z_d = z_q - a;
      end
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  assign done_o  = done_q;
  assign theta_o = zero_q ? '0 : z_q;

endmodule

@@ src/gtg_pid.sv @@
`timescale 1ns / 1ps

module gtg_pid #(
  parameter int AF = 13
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [AF+3:0]     theta_i,
  input  logic signed [15:0]       yaw_i,
  input  gtg_pkg::gtg_gain_t       gain_i,
  output logic                     done_o,
  output logic signed [13:0]       turn_rate_o
);
  import gtg_pkg::*;

  localparam int ZW = AF + 4;
  localparam int EW = AF + 8;
  localparam int YAW_UP = (AF >= IoAngleFrac) ? AF - IoAngleFrac : 0;
  localparam int YAW_DN = (AF < IoAngleFrac) ? IoAngleFrac - AF : 0;
  localparam int E_UP   = (IoAngleFrac >= AF) ? IoAngleFrac - AF : 0;
  localparam int E_DN   = (AF > IoAngleFrac) ? AF - IoAngleFrac : 0;
  localparam logic signed [EW-1:0] YAW_RND = (YAW_DN > 0) ? EW'(1 << (YAW_DN - 1)) : '0;
  localparam logic signed [EW-1:0] E_RND   = (E_DN > 0) ? EW'(1 << (E_DN - 1)) : '0;
  localparam logic [63:0] PI64 = (PI_Q30 + (64'd1 << (29 - AF))) >> (30 - AF);
  localparam logic signed [EW-1:0] PI_F = EW'(PI64);
  localparam int PW = 49;
  localparam int AW = 51;
  localparam int WW = AW - 8;
  localparam logic signed [WW-1:0] LIM_P = WW'(TurnLimit);
  localparam logic signed [WW-1:0] LIM_N = -LIM_P;
  localparam logic signed [32:0] SUM_MAX = 33'sd2147483647;
  localparam logic signed [32:0] SUM_MIN = -33'sd2147483648;

  typedef enum logic [5:0] {
    P_IDLE  = 6'b000001,
    P_MUL_P = 6'b000010,
    P_MUL_I = 6'b000100,
    P_MUL_D = 6'b001000,
    P_ACC   = 6'b010000,
    P_RND   = 6'b100000
  } pid_state_e;

  pid_state_e state_q, state_d;

  logic signed [31:0] error_sum_q;
  logic signed [15:0] last_error_q;
  logic signed [15:0] e_q;
  logic signed [31:0] sum_q;
  logic signed [16:0] diff_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic signed [13:0] turn_q;
  logic done_q;

  logic signed [EW-1:0] yaw_ext, yaw_r, theta_ext, err, err_w, e_full;
  logic signed [15:0] e_new;
  logic signed [32:0] sum_raw;
  logic signed [31:0] sum_new;
  logic signed [15:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [PW-1:0] prod_d;
  logic signed [WW-1:0] w_r;
  logic signed [13:0] w_c;

  // heading error, wrapped and rounded to Q3.13
  assign yaw_ext   = {{(EW-16){yaw_i[15]}}, yaw_i};
  assign yaw_r     = ((yaw_ext <<< YAW_UP) + YAW_RND) >>> YAW_DN;
  assign theta_ext = {{(EW-ZW){theta_i[ZW-1]}}, theta_i};
  assign err       = theta_ext - yaw_r;

  always_comb begin
    if (err > PI_F) begin
      err_w = err - (PI_F <<< 1);
    end else if (err <= -PI_F) begin
      err_w = err + (PI_F <<< 1);
    end else begin
      err_w = err;
    end
  end

  assign e_full = ((err_w <<< E_UP) + E_RND) >>> E_DN;
  assign e_new  = 16'(e_full);

  // saturating error sum
  assign sum_raw = {error_sum_q[31], error_sum_q} + {{17{e_new[15]}}, e_new};

  always_comb begin
    if (sum_raw > SUM_MAX) begin
      sum_new = 32'(SUM_MAX);
    end else if (sum_raw < SUM_MIN) begin
      sum_new = 32'(SUM_MIN);
    end else begin
      sum_new = 32'(sum_raw);
    end
  end

  // shared multiplier operands
  always_comb begin
    case (state_q)
      P_MUL_I: begin
        mul_a = gain_i.gain_i;
        mul_b = {sum_q[31], sum_q};
      end
      P_MUL_D: begin
        mul_a = gain_i.gain_d;
        mul_b = {{16{diff_q[16]}}, diff_q};
      end
      default: begin
        mul_a = gain_i.gain_p;
        mul_b = {{17{e_q[15]}}, e_q};
      end
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // round to Q1.13 and clamp
  assign w_r = WW'((acc_q + AW'(128)) >>> 8);

  always_comb begin
    if (w_r > LIM_P) begin
      w_c = 14'(LIM_P);
    end else if (w_r < LIM_N) begin
      w_c = 14'(LIM_N);
    end else begin
      w_c = 14'(w_r);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      P_IDLE:  if (start_i) state_d = P_MUL_P;
      P_MUL_P: state_d = P_MUL_I;
      P_MUL_I: state_d = P_MUL_D;
      P_MUL_D: state_d = P_ACC;
      P_ACC:   state_d = P_RND;
      P_RND:   state_d = P_IDLE;
      default: state_d = P_IDLE;
    endcase
  end

  // control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= P_IDLE;
      done_q       <= 1'b0;
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == P_RND);
      if ((state_q == P_IDLE) && start_i) begin
        error_sum_q  <= sum_new;
        last_error_q <= e_new;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if ((state_q == P_IDLE) && start_i) begin
      e_q    <= e_new;
      sum_q  <= sum_new;
      diff_q <= 17'(e_new) - 17'(last_error_q);
    end
    prod_q <= prod_d;
    case (state_q)
      P_MUL_I: acc_q <= AW'(prod_q);
      P_MUL_D: acc_q <= acc_q + AW'(prod_q);
      P_ACC:   acc_q <= acc_q + AW'(prod_q);
      P_RND:   turn_q <= w_c;
      default: ;
    endcase
  end

  assign done_o      = done_q;
  assign turn_rate_o = turn_q;

endmodule

@@ src/go_to_goal_heading_pid.sv @@
`timescale 1ns / 1ps
// path: CORDIC pre-rotation and rotation loop, pid states P_MUL_P to P_RND, output register
// requests: one in flight at a time, set by the CORDIC rotation loop, one micro-rotation
//   per cycle, and the shared pid multiplier; a new one is accepted once the result is loaded
// a finished result waits in the output register while the next request is accepted
// reset: asynchronous active low; control, config, error sum and previous error clear to zero

module go_to_goal_heading_pid #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gtg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gtg_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gtg_pkg::gtg_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gtg_pkg::gtg_out_t              out_data_o
);
  import gtg_pkg::*;

  localparam int ZW = ANGLE_FRAC_BITS + 4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CORD = 4'b0010,
    ST_PID  = 4'b0100,
    ST_OUT  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;

  logic signed [23:0] goal_x_q, goal_y_q;
  gtg_gain_t          gain_q;
  logic [14:0]        cruise_q;
  logic signed [15:0] yaw_q;
  logic               out_valid_q;
  gtg_out_t           out_q;

  logic               in_acc, out_load;
  logic signed [24:0] dx, dy;
  logic               cord_done, pid_done;
  logic signed [ZW-1:0] theta;
  logic signed [13:0] turn_rate;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      gain_q   <= '0;
      cruise_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GOAL_X:       goal_x_q      <= cfg_data_i;
        REG_GOAL_Y:       goal_y_q      <= cfg_data_i;
        REG_GAIN_P:       gain_q.gain_p <= cfg_data_i[15:0];
        REG_GAIN_I:       gain_q.gain_i <= cfg_data_i[15:0];
        REG_GAIN_D:       gain_q.gain_d <= cfg_data_i[15:0];
        REG_CRUISE_SPEED: cruise_q      <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // request handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // goal vector
  assign dx = 25'(goal_x_q) - 25'(in_data_i.pos_x);
  assign dy = 25'(goal_y_q) - 25'(in_data_i.pos_y);

  gtg_cordic #(
    .STEPS (CORDIC_STEPS),
    .AF    (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .dx_i    (dx),
    .dy_i    (dy),
    .done_o  (cord_done),
    .theta_o (theta)
  );

  gtg_pid #(
    .AF (ANGLE_FRAC_BITS)
  ) u_pid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cord_done),
    .theta_i     (theta),
    .yaw_i       (yaw_q),
    .gain_i      (gain_q),
    .done_o      (pid_done),
    .turn_rate_o (turn_rate)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CORD;
      ST_CORD: if (cord_done) state_d = ST_PID;
      ST_PID:  if (pid_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      yaw_q <= in_data_i.yaw;
    end
    if (out_load) begin
      out_q.turn_rate <= turn_rate;
      out_q.speed_out <= cruise_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // cordic finishes only while the sequencer waits for it
  a_cord_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> (state_q == ST_CORD))
    else $error("cordic done outside its phase");

  // pid finishes only while the sequencer waits for it
  a_pid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pid_done |-> (state_q == ST_PID))
    else $error("pid done outside its phase");

  // a loaded result is within the turn limit
  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_q.turn_rate <= 14'(TurnLimit)) && (out_q.turn_rate >= -14'(TurnLimit)))
    else $error("turn rate beyond limit");

  // sequencer state stays one-hot
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");
`endif

endmodule
